FILE: sv/pte_pkg.sv
package pte_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [7:0] STEP_MAX = 8'd205;

    typedef enum logic [1:0] {
        OP_SPAWN  = 2'd0,
        OP_TICK   = 2'd1,
        OP_RENDER = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // one stored particle
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0]        life;
        logic [15:0]        max_life;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         opacity;
        logic [7:0]         side;
    } t_entry;

    // request to the alpha divider
    typedef struct packed {
        logic        start;
        logic [23:0] num;
        logic [15:0] den;
    } t_div_req;

    // vel * step / 16384, rounded half away from zero
    function automatic logic signed [10:0] round_move(input logic signed [24:0] p);
        logic [24:0] m;
        logic [24:0] q;
        m = p[24] ? 25'(-p) : 25'(p);
        q = (m + 25'd8192) >> 14;
        round_move = p[24] ? 11'(-$signed({1'b0, q[9:0]})) : $signed({1'b0, q[9:0]});
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    // whole pixels, truncated toward zero
    function automatic logic [11:0] to_pixel(input logic signed [15:0] v);
        logic signed [11:0] t;
        t = v[15:4];
        if (v[15] && (v[3:0] != 4'd0)) begin
            t = t + 12'sd1;
        end
        to_pixel = t;
    endfunction

endpackage

FILE: sv/pte_if.sv
interface pte_in_if;
    import pte_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [15:0] lifetime;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  opacity;
    logic [7:0]  square_size;
    logic [15:0] time_step;
    modport source (output valid, operation, pos_x, pos_y, vel_x, vel_y, lifetime,
                    red, green, blue, opacity, square_size, time_step, input ready);
    modport sink (input valid, operation, pos_x, pos_y, vel_x, vel_y, lifetime,
                  red, green, blue, opacity, square_size, time_step, output ready);
endinterface

interface pte_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic [7:0]  side;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  faded_alpha;
    logic [6:0]  live_count;
    logic        is_last;
    modport source (output valid, status, pixel_x, pixel_y, side, out_red, out_green,
                    out_blue, faded_alpha, live_count, is_last, input ready);
    modport sink (input valid, status, pixel_x, pixel_y, side, out_red, out_green,
                  out_blue, faded_alpha, live_count, is_last, output ready);
endinterface

interface pte_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: sv/pte_alpha_div.sv
module pte_alpha_div
    import pte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_div_req   i_req,
    output logic       o_done,
    output logic [7:0] o_quot
);
    logic [15:0] r_rem;
    logic [7:0]  r_lo;
    logic [15:0] r_den;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] n_try;

    // quotient fits 8 bits, so start with the upper numerator as remainder
    assign n_try = {r_rem, r_lo[7]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num[23:8];
                r_lo   <= i_req.num[7:0];
                r_den  <= i_req.den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one quotient bit per cycle
                if (n_try >= {1'b0, r_den}) begin
                    r_rem <= 16'(n_try - {1'b0, r_den});
                    r_lo  <= {r_lo[6:0], 1'b1};
                end else begin
                    r_rem <= n_try[15:0];
                    r_lo  <= {r_lo[6:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;
endmodule

FILE: sv/particle_table_engine.sv
// Spawn, clear, empty render and idle tick: the item moves to the emit state, which registers
// the result word once the output slot is free.
// Tick walks the table one stored particle at a time (memory read, then update and write back),
// then emits the done word. Render gives one word per particle: memory read, load, wait on the
// alpha divider, then emit; the divider wait is skipped when no division is needed (zero maximum
// life or saturated alpha). One item at a time; a new item is accepted once the previous one has
// registered its last word. Synchronous active-low reset empties the table and clears frozen; memory contents stay.
module particle_table_engine
    import pte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pte_in_if.sink    i_in,
    pte_out_if.source o_out,
    pte_cfg_if.sink   i_cfg
);
    typedef enum logic [2:0] {
        S_IDLE, S_TRD, S_TUP, S_RRD, S_RLD, S_RDIV, S_REMIT, S_EMIT
    } t_state;

    t_state r_state;
    t_entry mem [TABLE_DEPTH];
    t_entry r_rd;
    logic [CNT_W-1:0] r_count, r_i, r_w;
    logic [7:0]  r_step;
    logic        r_frozen;
    logic [1:0]  r_st;
    logic [7:0]  r_fa;

    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [11:0] r_opx, r_opy;
    logic [7:0]  r_oside, r_ored, r_ogreen, r_oblue, r_oalpha;
    logic [CNT_W-1:0] r_olive;
    logic        r_olast;

    logic        we;
    logic [ADDR_W-1:0] waddr;
    t_entry      wdata, spawn_e, upd_e;
    logic        accept, slot_free, alive, emit_now;
    logic signed [16:0] life_n;
    logic signed [24:0] mx, my;
    logic [8:0]  dvy;
    logic [23:0] num;
    t_div_req    div_req;
    logic        div_done;
    logic [7:0]  div_q;

    assign accept    = i_in.valid && i_in.ready;
    assign slot_free = !r_ovalid || o_out.ready;
    assign emit_now  = slot_free && (r_state == S_REMIT || r_state == S_EMIT);
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // build a new entry from the input word
    always_comb begin
        spawn_e.pos_x    = i_in.pos_x;
        spawn_e.pos_y    = i_in.pos_y;
        spawn_e.vel_x    = i_in.vel_x;
        spawn_e.vel_y    = i_in.vel_y;
        spawn_e.life     = i_in.lifetime;
        spawn_e.max_life = i_in.lifetime;
        spawn_e.red      = i_in.red;
        spawn_e.green    = i_in.green;
        spawn_e.blue     = i_in.blue;
        spawn_e.opacity  = i_in.opacity;
        spawn_e.side     = i_in.square_size;
    end

    // advance the entry just read
    always_comb begin
        life_n = $signed({1'b0, r_rd.life}) - $signed({9'b0, r_step});
        alive  = !life_n[16] && (life_n != 17'sd0);
        mx     = r_rd.vel_x * $signed({1'b0, r_step});
        my     = r_rd.vel_y * $signed({1'b0, r_step});
        dvy    = 9'((14'd45 * {6'b0, r_step} + 14'd16) >> 5);
        upd_e       = r_rd;
        upd_e.life  = life_n[15:0];
        upd_e.pos_x = sat16(18'(r_rd.pos_x) + 18'(round_move(mx)));
        upd_e.pos_y = sat16(18'(r_rd.pos_y) + 18'(round_move(my)));
        upd_e.vel_y = sat16(18'(r_rd.vel_y) + $signed({9'b0, dvy}));
    end

    // write port select
    always_comb begin
        we    = 1'b0;
        waddr = r_count[ADDR_W-1:0];
        wdata = spawn_e;
        if (r_state == S_IDLE && accept && t_op'(i_in.operation) == OP_SPAWN
            && r_count < CNT_W'(TABLE_DEPTH)) begin
            we = 1'b1;
        end else if (r_state == S_TUP && alive) begin
            we    = 1'b1;
            waddr = r_w[ADDR_W-1:0];
            wdata = upd_e;
        end
    end

    // particle memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (r_state == S_TRD || r_state == S_RRD) begin
            r_rd <= mem[r_i[ADDR_W-1:0]];
        end
    end

    assign num = r_rd.opacity * r_rd.life;
    assign div_req.start = (r_state == S_RLD) && (r_rd.max_life != 16'd0)
                           && (num[23:8] < r_rd.max_life);
    assign div_req.num = num;
    assign div_req.den = r_rd.max_life;

    pte_alpha_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_frozen <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frozen <= i_cfg.data;
            end
            // drop the taken word unless a new one replaces it
            if (o_out.ready && !emit_now) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_i     <= '0;
                        r_w     <= '0;
                        r_step  <= (i_in.time_step > 16'(STEP_MAX))
                                   ? STEP_MAX : i_in.time_step[7:0];
                        case (t_op'(i_in.operation))
                            OP_SPAWN: begin
                                r_state <= S_EMIT;
                                if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                    r_st    <= ST_OK;
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_st <= ST_DROP;
                                end
                            end
                            OP_TICK: begin
                                r_st <= ST_OK;
                                if (!r_frozen && i_in.time_step != 16'd0
                                    && r_count != '0) begin
                                    r_state <= S_TRD;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            OP_RENDER: begin
                                if (r_count == '0) begin
                                    r_st    <= ST_EMPTY;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_state <= S_RRD;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_st    <= ST_OK;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_st    <= ST_OK;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_TRD: r_state <= S_TUP;
                S_TUP: begin
                    // compact survivors toward the front
                    if (alive) begin
                        r_w <= r_w + 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_count) begin
                        r_count <= alive ? r_w + 1'b1 : r_w;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_TRD;
                    end
                end
                S_RRD: r_state <= S_RLD;
                S_RLD: begin
                    if (r_rd.max_life == 16'd0) begin
                        r_fa    <= 8'd0;
                        r_state <= S_REMIT;
                    end else if (num[23:8] >= r_rd.max_life) begin
                        r_fa    <= 8'd255;
                        r_state <= S_REMIT;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_fa    <= div_q;
                        r_state <= S_REMIT;
                    end
                end
                S_REMIT: begin
                    if (slot_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_OK;
                        r_opx     <= to_pixel(r_rd.pos_x);
                        r_opy     <= to_pixel(r_rd.pos_y);
                        r_oside   <= r_rd.side;
                        r_ored    <= r_rd.red;
                        r_ogreen  <= r_rd.green;
                        r_oblue   <= r_rd.blue;
                        r_oalpha  <= r_fa;
                        r_olive   <= r_count;
                        r_olast   <= (r_i + 1'b1 == r_count);
                        r_i       <= r_i + 1'b1;
                        r_state   <= (r_i + 1'b1 == r_count) ? S_IDLE : S_RRD;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_st;
                        r_opx     <= '0;
                        r_opy     <= '0;
                        r_oside   <= '0;
                        r_ored    <= '0;
                        r_ogreen  <= '0;
                        r_oblue   <= '0;
                        r_oalpha  <= '0;
                        r_olive   <= r_count;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_ostatus;
    assign o_out.pixel_x     = r_opx;
    assign o_out.pixel_y     = r_opy;
    assign o_out.side        = r_oside;
    assign o_out.out_red     = r_ored;
    assign o_out.out_green   = r_ogreen;
    assign o_out.out_blue    = r_oblue;
    assign o_out.faded_alpha = r_oalpha;
    assign o_out.live_count  = 7'(r_olive);
    assign o_out.is_last     = r_olast;
endmodule

FILE: dv/pte_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are provided by the RTL (sv/pte_if.sv); nothing extra is needed here.
package pte_tb_types;
    import pte_pkg::*;

    // one expected output word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic [7:0]         side;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [6:0]         live_count;
        logic               is_last;
    } t_word;
endpackage

FILE: dv/particle_table_engine_test.sv
`timescale 1ns / 1ps
module particle_table_engine_test;
    import pte_pkg::*;
    import pte_tb_types::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pte_in_if  in_ch();
    pte_out_if out_ch();
    pte_cfg_if cfg_ch();

    particle_table_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the particle table
    t_entry table_q[$];
    logic   frozen_m;
    t_word  pending_q[$];
    int     errors;
    logic   stall_free;
    int     hold_left;

    // round half away from zero, den > 0
    function automatic longint round_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_word plain_word(logic [1:0] st);
        t_word w;
        w = '0;
        w.status = st;
        w.live_count = 7'(table_q.size());
        w.is_last = 1'b1;
        return w;
    endfunction

    // append one expected word
    function automatic void expect_word(t_word w);
        pending_q = {pending_q, w};
    endfunction

    // advance the shadow table and queue the words this item produces
    task automatic predict_item(t_entry e, logic [1:0] op, logic [15:0] dt);
        t_entry kept[$];
        t_entry p;
        t_word  w;
        int     step;
        int     lf;
        int     n;
        int     fa;
        case (op)
            OP_SPAWN: begin
                if (table_q.size() >= TABLE_DEPTH) begin
                    expect_word(plain_word(ST_DROP));
                end else begin
                    table_q = {table_q, e};
                    expect_word(plain_word(ST_OK));
                end
            end
            OP_TICK: begin
                if (!frozen_m && dt != 0) begin
                    step = (dt > STEP_MAX) ? STEP_MAX : dt;
                    foreach (table_q[i]) begin
                        p = table_q[i];
                        lf = int'(p.life) - step;
                        if (lf > 0) begin
                            p.pos_x = clip16(longint'(p.pos_x)
                                + round_div(longint'(p.vel_x) * step, 16384));
                            p.pos_y = clip16(longint'(p.pos_y)
                                + round_div(longint'(p.vel_y) * step, 16384));
                            p.vel_y = clip16(longint'(p.vel_y) + round_div(45 * step, 32));
                            p.life = lf[15:0];
                            kept = {kept, p};
                        end
                    end
                    table_q = kept;
                end
                expect_word(plain_word(ST_OK));
            end
            OP_CLEAR: begin
                table_q.delete();
                expect_word(plain_word(ST_OK));
            end
            default: begin
                n = table_q.size();
                if (n == 0) begin
                    expect_word(plain_word(ST_EMPTY));
                end else begin
                    foreach (table_q[i]) begin
                        p = table_q[i];
                        w = '0;
                        w.status = ST_OK;
                        w.pixel_x = 12'(int'(p.pos_x) / 16);
                        w.pixel_y = 12'(int'(p.pos_y) / 16);
                        w.side = p.side;
                        w.red = p.red;
                        w.green = p.green;
                        w.blue = p.blue;
                        fa = 0;
                        if (p.max_life != 0) begin
                            fa = (int'(p.opacity) * int'(p.life)) / int'(p.max_life);
                            if (fa > 255) fa = 255;
                        end
                        w.alpha = fa[7:0];
                        w.live_count = 7'(n);
                        w.is_last = (i == n - 1);
                        expect_word(w);
                    end
                end
            end
        endcase
    endtask

    // send one item after a random gap, none when stall_free is set; valid drops only when there is a gap
    task automatic send_item(t_entry e, logic [1:0] op, logic [15:0] dt);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.pos_x       <= e.pos_x;
        in_ch.pos_y       <= e.pos_y;
        in_ch.vel_x       <= e.vel_x;
        in_ch.vel_y       <= e.vel_y;
        in_ch.lifetime    <= e.life;
        in_ch.red         <= e.red;
        in_ch.green       <= e.green;
        in_ch.blue        <= e.blue;
        in_ch.opacity     <= e.opacity;
        in_ch.square_size <= e.side;
        in_ch.time_step   <= dt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(e, op, dt);
    endtask

    function automatic t_entry rand_entry(bit wild);
        t_entry e;
        e = '0;
        e.pos_x = wild ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
        e.pos_y = wild ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
        e.vel_x = 16'($urandom);
        e.vel_y = 16'($urandom);
        e.life = wild ? 16'($urandom) : 16'($urandom_range(0, 3000));
        e.max_life = e.life;
        e.red = 8'($urandom);
        e.green = 8'($urandom);
        e.blue = 8'($urandom);
        e.opacity = 8'($urandom);
        e.side = 8'($urandom);
        return e;
    endfunction

    task automatic spawn(t_entry e);
        send_item(e, OP_SPAWN, 16'd0);
    endtask

    task automatic do_op(logic [1:0] op, logic [15:0] dt);
        send_item('0, op, dt);
    endtask

    // write the frozen register once nothing is in flight
    task automatic set_frozen(logic v);
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        frozen_m = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // check each output word against the oldest expectation
    always @(posedge i_clk) begin
        t_word exp_w;
        t_word got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = out_ch.status;
            got.pixel_x = out_ch.pixel_x;
            got.pixel_y = out_ch.pixel_y;
            got.side = out_ch.side;
            got.red = out_ch.out_red;
            got.green = out_ch.out_green;
            got.blue = out_ch.out_blue;
            got.alpha = out_ch.faded_alpha;
            got.live_count = out_ch.live_count;
            got.is_last = out_ch.is_last;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected word, expected none, got %h", $time, got);
                errors++;
            end else begin
                exp_w = pending_q.pop_front();
                if (got !== exp_w) begin
                    $display("%0t mismatch expected %p actual %p", $time, exp_w, got);
                    errors++;
                end
            end
        end
    end

    // random back pressure: ready may drop after each taken word, unless stall_free is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end else if (stall_free) begin
            out_ch.ready <= 1'b1;
            hold_left = 0;
        end else if (out_ch.valid && out_ch.ready) begin
            hold_left = $urandom_range(0, 14);
            out_ch.ready <= (hold_left == 0);
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= (hold_left == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic test_extremes();
        t_entry e;
        e = '0;
        e.pos_x = 16'sh7fff; e.pos_y = 16'sh8000;
        e.vel_x = 16'sh7fff; e.vel_y = 16'sh7fff;
        e.life = 16'hffff; e.max_life = 16'hffff;
        e.red = 8'hff; e.green = 8'hff; e.blue = 8'hff; e.opacity = 8'hff; e.side = 8'hff;
        do_op(OP_RENDER, 16'd0);
        spawn(e);
        e.pos_x = 16'sh8000; e.pos_y = 16'sh7fff;
        e.vel_x = 16'sh8000; e.vel_y = 16'sh8000;
        spawn(e);
        e = '0;
        e.pos_x = -16'sd17; e.pos_y = 16'sd17;
        spawn(e);
        do_op(OP_RENDER, 16'd0);
        do_op(OP_TICK, 16'd0);
        do_op(OP_TICK, 16'hffff);
        do_op(OP_TICK, 16'd1);
        do_op(OP_RENDER, 16'd0);
        do_op(OP_CLEAR, 16'd0);
        do_op(OP_RENDER, 16'd0);
    endtask

    task automatic test_frozen();
        spawn(rand_entry(1'b0));
        set_frozen(1'b1);
        do_op(OP_TICK, 16'd100);
        do_op(OP_RENDER, 16'd0);
        set_frozen(1'b0);
        do_op(OP_TICK, 16'd100);
        do_op(OP_RENDER, 16'd0);
    endtask

    task automatic test_full_table();
        do_op(OP_CLEAR, 16'd0);
        repeat (TABLE_DEPTH + 2) spawn(rand_entry(1'b1));
        do_op(OP_RENDER, 16'd0);
        do_op(OP_CLEAR, 16'd0);
    endtask

    task automatic test_random(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            stall_free = ($urandom_range(0, 9) == 0);
            if (r < 45) spawn(rand_entry($urandom_range(0, 3) == 0));
            else if (r < 70) do_op(OP_TICK, ($urandom_range(0, 3) == 0)
                                   ? 16'($urandom) : 16'($urandom_range(0, 250)));
            else if (r < 95) do_op(OP_RENDER, 16'($urandom));
            else do_op(OP_CLEAR, 16'($urandom));
            if ($urandom_range(0, 79) == 0) set_frozen(1'($urandom_range(0, 1)));
        end
        stall_free = 1'b0;
    endtask

    initial begin
        errors = 0;
        frozen_m = 1'b0;
        stall_free = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.operation <= OP_SPAWN;
        in_ch.pos_x <= '0; in_ch.pos_y <= '0;
        in_ch.vel_x <= '0; in_ch.vel_y <= '0;
        in_ch.lifetime <= '0; in_ch.red <= '0; in_ch.green <= '0;
        in_ch.blue <= '0; in_ch.opacity <= '0; in_ch.square_size <= '0;
        in_ch.time_step <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_frozen(1'b0);
        test_extremes();
        test_frozen();
        test_full_table();
        test_random(385);
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("particle_table_engine_test passed");
        end else begin
            $display("particle_table_engine_test failed");
        end
        $finish;
    end

    // hard stop
    initial begin
        #50ms;
        $display("particle_table_engine_test failed");
        $finish;
    end
endmodule
